@@ rtl/core/group_cluster_hysteresis_core_macros.svh @@
// Assertion macros for the group cluster hysteresis core.
// Used by group_cluster_hysteresis_core.sv; expects clk and rst_n in scope.
`ifndef GROUP_CLUSTER_HYSTERESIS_CORE_MACROS_SVH
`define GROUP_CLUSTER_HYSTERESIS_CORE_MACROS_SVH

// same-cycle implication
`define GCH_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("group_cluster_hysteresis_core: check failed");

// next-cycle implication
`define GCH_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("group_cluster_hysteresis_core: check failed");

`endif

@@ rtl/core/gch_pkg.sv @@
// Package for the group cluster hysteresis core: register map, reset values,
// field widths and the staged word type. No dependencies.
`timescale 1ns / 1ps

package gch_pkg;

    localparam int TIME_W  = 64;
    localparam int DEM_W   = 32;
    localparam int SUM_W   = DEM_W + 1;
    localparam int HIST_W  = 4;
    localparam int SPAN_W  = DEM_W + HIST_W;
    localparam int RATE_W  = 29;
    localparam int ADDR_W  = 6;
    localparam int IN_W    = 168;
    localparam int OUT_W   = 136;

    // register indexes, byte address = 8 * index
    localparam logic [2:0] REG_UP_THRESHOLD    = 3'd0;
    localparam logic [2:0] REG_DOWN_THRESHOLD  = 3'd1;
    localparam logic [2:0] REG_DOWN_HOLD_NS    = 3'd2;
    localparam logic [2:0] REG_WINDOW_NS       = 3'd3;
    localparam logic [2:0] REG_HISTORY_WINDOWS = 3'd4;

    localparam logic [DEM_W-1:0]  UP_RESET     = 32'd20000000;
    localparam logic [DEM_W-1:0]  DOWN_RESET   = 32'd19000000;
    localparam logic [TIME_W-1:0] HOLD_RESET   = 64'd0;
    localparam logic [DEM_W-1:0]  WINDOW_RESET = 32'd20000000;
    localparam logic [HIST_W-1:0] HIST_RESET   = 4'd5;
    localparam logic [RATE_W-1:0] RATE_RESET   = 29'd2000000;

    // divide by ten: (x * RECIP_10) >> RECIP_SHIFT, exact for 32-bit x
    localparam logic [TIME_W-1:0] RECIP_10    = 64'h0000_0000_CCCC_CCCD;
    localparam int                RECIP_SHIFT = 35;

    typedef struct packed {
        logic [TIME_W-1:0] now;
        logic [DEM_W-1:0]  demand;
        logic              stale;
        logic              boost;
        logic              last;
        logic              flush;
        logic              maxb;
    } st_word_t;

endpackage

@@ rtl/core/group_cluster_hysteresis_core.sv @@
// Group cluster hysteresis core: demand summing and big-cluster preference flag.
// Depends on gch_pkg and group_cluster_hysteresis_core_macros.svh.
//
// Usage:
//  Input stream s_*: one task record per word, s_tlast on the final record of an
//  update, s_tuser = group_empty. A word with group_empty set or multi_cluster
//  clear ends the update on its own and forces the flag clear.
//  Output stream m_*: one result word per ended update, none for other records.
//  Configuration: APB write/read of five registers at byte address 8 * index.
//  Path: a final record is registered in the input stage register, and its result
//  word then in the output register. Throughput: one record per cycle while no
//  record that ends an update is stalled; every record is summed and every decision
//  made combinationally between the input stage register and the output register.
//  Stall: while m_tready is low and a result waits, a further record that ends an
//  update (final or flush) holds in the input stage and s_tready drops; other records
//  keep flowing until the next one that ends an update.
//  Reset: flag, hold and timing state clear to zero, registers take their
//  default values, both streams come up empty.
`timescale 1ns / 1ps
`include "group_cluster_hysteresis_core_macros.svh"

module group_cluster_hysteresis_core
(
    input  logic                          clk,
    input  logic                          rst_n,

    // [63:0] now_ns, [127:64] task_last_seen, [159:128] task_demand,
    // [160] task_boost_big, [161] multi_cluster, [162] max_boost_mode, rest zero
    input  logic [gch_pkg::IN_W-1:0]      s_tdata,
    input  logic                          s_tlast,   // last_task
    input  logic [0:0]                    s_tuser,   // [0] group_empty
    input  logic                          s_tvalid,
    output logic                          s_tready,

    // [0] updated, [1] prefer_big, [2] changed, [66:3] active_since,
    // [130:67] demand_sum, rest zero
    output logic [gch_pkg::OUT_W-1:0]     m_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gch_pkg::ADDR_W-1:0]    paddr,
    input  logic [63:0]                   pwdata,
    output logic [63:0]                   prdata,
    output logic                          pready
);

    localparam int TW = gch_pkg::TIME_W;
    localparam int DW = gch_pkg::DEM_W;
    localparam int SW = gch_pkg::SUM_W;

    // configuration
    logic [DW-1:0]              up_reg;
    logic [DW-1:0]              down_reg;
    logic [TW-1:0]              hold_reg;
    logic [DW-1:0]              window_reg;
    logic [gch_pkg::HIST_W-1:0] hist_reg;
    logic [gch_pkg::RATE_W-1:0] rate_reg;
    logic [gch_pkg::RATE_W-1:0] rate_next;
    logic [2*TW-1:0]            rate_prod;
    logic                       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign rate_prod = {{TW{1'b0}}, {(TW-DW){1'b0}}, pwdata[DW-1:0]}
                       * {{TW{1'b0}}, gch_pkg::RECIP_10};
    assign rate_next = rate_prod[gch_pkg::RECIP_SHIFT +: gch_pkg::RATE_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_reg     <= gch_pkg::UP_RESET;
            down_reg   <= gch_pkg::DOWN_RESET;
            hold_reg   <= gch_pkg::HOLD_RESET;
            window_reg <= gch_pkg::WINDOW_RESET;
            hist_reg   <= gch_pkg::HIST_RESET;
            rate_reg   <= gch_pkg::RATE_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[5:3])
                gch_pkg::REG_UP_THRESHOLD:    up_reg <= pwdata[DW-1:0];
                gch_pkg::REG_DOWN_THRESHOLD:  down_reg <= pwdata[DW-1:0];
                gch_pkg::REG_DOWN_HOLD_NS:    hold_reg <= pwdata;
                gch_pkg::REG_WINDOW_NS:
                begin
                    window_reg <= pwdata[DW-1:0];
                    rate_reg   <= rate_next;
                end
                gch_pkg::REG_HISTORY_WINDOWS: hist_reg <= pwdata[gch_pkg::HIST_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[5:3])
            gch_pkg::REG_UP_THRESHOLD:    prdata = {{(64-DW){1'b0}}, up_reg};
            gch_pkg::REG_DOWN_THRESHOLD:  prdata = {{(64-DW){1'b0}}, down_reg};
            gch_pkg::REG_DOWN_HOLD_NS:    prdata = hold_reg;
            gch_pkg::REG_WINDOW_NS:       prdata = {{(64-DW){1'b0}}, window_reg};
            gch_pkg::REG_HISTORY_WINDOWS: prdata = {{(64-gch_pkg::HIST_W){1'b0}}, hist_reg};
            default:                      prdata = 64'd0;
        endcase
    end

    // input stage: staleness test done here
    logic [gch_pkg::SPAN_W-1:0] span;
    logic [TW-1:0]              span_floor;
    gch_pkg::st_word_t          in_word;
    gch_pkg::st_word_t          st_reg;
    logic                       st_valid_reg;
    logic                       st_go;
    logic                       st_emits;
    logic                       out_free;

    assign span       = window_reg * {{DW{1'b0}}, hist_reg};
    assign span_floor = s_tdata[63:0] - {{(TW-gch_pkg::SPAN_W){1'b0}}, span};

    always_comb
    begin
        in_word.now    = s_tdata[63:0];
        in_word.demand = s_tdata[159:128];
        in_word.stale  = s_tdata[127:64] < span_floor;
        in_word.boost  = s_tdata[160];
        in_word.last   = s_tlast;
        in_word.flush  = s_tuser[0] || !s_tdata[161];
        in_word.maxb   = s_tdata[162];
    end

    assign out_free = !m_tvalid || m_tready;
    assign st_emits = st_reg.last || st_reg.flush;
    assign st_go    = st_valid_reg && (!st_emits || out_free);
    assign s_tready = !st_valid_reg || st_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_valid_reg <= 1'b0;
        else if (s_tready)
            st_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            st_reg <= in_word;
    end

    // decision state
    logic          flag_reg,    flag_next;
    logic [TW-1:0] pend_reg,    pend_next;
    logic [TW-1:0] last_dec_reg, last_dec_next;
    logic [TW-1:0] set_time_reg, set_time_next;
    logic [SW-1:0] sum_reg,     sum_next;
    logic          saw_reg,     saw_next;
    logic          stopped_reg, stopped_next;

    // per-word datapath
    logic          rec_take;
    logic          boost_hit;
    logic          add_hit;
    logic [SW-1:0] sum_add;
    logic [SW-1:0] sum_now;
    logic          stop_now;
    logic          saw_now;
    logic          limited;
    logic [TW-1:0] since_set;
    logic [TW-1:0] pend_age;
    logic [SW-1:0] dmd;
    logic          flag_dec;
    logic [TW-1:0] pend_dec;

    assign rec_take  = !stopped_reg && !st_reg.flush;
    assign boost_hit = rec_take && st_reg.boost;
    assign add_hit   = rec_take && !st_reg.boost && !st_reg.stale;
    assign sum_add   = sum_reg + {1'b0, st_reg.demand};
    assign sum_now   = add_hit ? sum_add : sum_reg;
    assign stop_now  = stopped_reg || boost_hit || (add_hit && (sum_add > {1'b0, up_reg}));
    assign saw_now   = saw_reg || boost_hit;
    assign limited   = (st_reg.now - last_dec_reg)
                       < {{(TW-gch_pkg::RATE_W){1'b0}}, rate_reg};
    assign since_set = st_reg.now - set_time_reg;
    assign pend_age  = st_reg.now - pend_reg;
    assign dmd       = st_reg.maxb ? {1'b0, up_reg} : sum_now;

    always_comb
    begin
        flag_dec = flag_reg;
        pend_dec = pend_reg;
        if (saw_now)
            flag_dec = 1'b0;
        else if (!flag_reg)
        begin
            if (dmd >= {1'b0, up_reg})
                flag_dec = 1'b1;
        end
        else if (dmd < {1'b0, down_reg})
        begin
            if ((hold_reg == '0) || (since_set < hold_reg))
            begin
                flag_dec = 1'b0;
                pend_dec = '0;
            end
            else if (pend_reg == '0)
                pend_dec = st_reg.now;
            else if (pend_age > hold_reg)
            begin
                flag_dec = 1'b0;
                pend_dec = '0;
            end
        end
        else
            pend_dec = '0;
    end

    // output word fields
    logic          o_updated;
    logic [SW-1:0] o_sum;

    always_comb
    begin
        flag_next     = flag_reg;
        pend_next     = pend_reg;
        last_dec_next = last_dec_reg;
        sum_next      = sum_now;
        saw_next      = saw_now;
        stopped_next  = stop_now;
        o_updated     = 1'b1;
        o_sum         = '0;
        if (st_reg.flush)
        begin
            flag_next    = 1'b0;
            sum_next     = '0;
            saw_next     = 1'b0;
            stopped_next = 1'b0;
        end
        else if (st_reg.last)
        begin
            sum_next     = '0;
            saw_next     = 1'b0;
            stopped_next = 1'b0;
            if (limited)
                o_updated = 1'b0;
            else
            begin
                flag_next     = flag_dec;
                pend_next     = pend_dec;
                last_dec_next = st_reg.now;
                o_sum         = sum_now;
            end
        end
        set_time_next = set_time_reg;
        if (flag_next != flag_reg)
            set_time_next = flag_next ? st_reg.now : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg     <= 1'b0;
            pend_reg     <= '0;
            last_dec_reg <= '0;
            set_time_reg <= '0;
            sum_reg      <= '0;
            saw_reg      <= 1'b0;
            stopped_reg  <= 1'b0;
        end
        else if (st_go)
        begin
            flag_reg     <= flag_next;
            pend_reg     <= pend_next;
            last_dec_reg <= last_dec_next;
            set_time_reg <= set_time_next;
            sum_reg      <= sum_next;
            saw_reg      <= saw_next;
            stopped_reg  <= stopped_next;
        end
    end

    // output register
    logic m_tvalid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (st_go && st_emits)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    logic [gch_pkg::OUT_W-1:0] m_tdata_reg;

    always_ff @(posedge clk)
    begin
        if (st_go && st_emits)
            m_tdata_reg <= {5'd0, {(TW-SW){1'b0}}, o_sum, set_time_next,
                            (flag_next != flag_reg), flag_next, o_updated};
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // checks
    `GCH_ASSERT_NOW(a_clear_flag_no_time, !flag_reg, set_time_reg == '0)
    `GCH_ASSERT_NEXT(a_accum_cleared, st_go && st_emits,
        (sum_reg == '0) && !saw_reg && !stopped_reg)
    `GCH_ASSERT_NOW(a_skip_no_change, m_tvalid_reg && !m_tdata_reg[0],
        !m_tdata_reg[2] && (m_tdata_reg[130:67] == '0))

endmodule
